>>> sv/mcgh_pkg.sv
// Shared types and codes for the metric counter, gauge and histogram table.
// Used by mcgh_out_stage and metric_counter_gauge_histogram_table_top; no dependencies.
package mcgh_pkg;

    localparam logic [47:0] CNT_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [3:0]  INF_INDEX = 4'd8;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_DEFINE = 2'd1,
        CMD_BOUND  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_UNUSED  = 2'd0,
        KIND_COUNTER = 2'd1,
        KIND_GAUGE   = 2'd2,
        KIND_HIST    = 2'd3
    } slot_kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNUSED = 2'd1,
        ST_NOBKT  = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        IK_ACK   = 3'd0,
        IK_VALUE = 3'd1,
        IK_BKT   = 3'd2,
        IK_SUM   = 3'd3,
        IK_COUNT = 3'd4
    } item_kind_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_LOOK, S_CLR, S_BCMP, S_SCAN, S_HITWR,
        S_RBKT, S_RINF, S_RSUM, S_RCNT, S_ACK, S_VAL
    } state_t;

    // One entry of the slot memory.
    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         total;
        logic signed [63:0] value;
        logic [47:0]        count;
    } slot_t;

    // One result as handed to the output stage.
    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         item_kind;
        logic [3:0]         bidx;
        logic signed [63:0] data;
        logic               last;
    } result_t;

endpackage

>>> sv/mcgh_out_stage.sv
// Output register of the statistics table: holds one result until the receiver takes it.
// Depends on mcgh_pkg for result_t.
module mcgh_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mcgh_pkg::result_t push_data,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,   // status[1:0], boundary_index[5:2], data[69:6], zero
    output logic [2:0]       m_tuser,   // item_kind[2:0]
    output logic             m_tlast
);
    import mcgh_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && free) begin
            data_reg <= push_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, data_reg.data, data_reg.bidx, data_reg.status};
    assign m_tuser  = data_reg.item_kind;
    assign m_tlast  = data_reg.last;

endmodule

>>> sv/metric_counter_gauge_histogram_table_top.sv
// Top level of the metric counter, gauge and histogram table.
// Depends on mcgh_pkg and mcgh_out_stage.
//
// Usage. Commands arrive on the s_ stream channel, one per transfer; s_tuser holds
// the command code. Results leave on the m_ stream channel; m_tuser holds the kind of
// result and m_tlast marks the final result of a command. Define, boundary and update
// commands give one acknowledge; a read gives one value, or for a histogram the
// cumulative bucket counts, the +Inf count, the sum and the count, and for an unused
// slot an acknowledge.
// Sequencing. All state lives in three single-port style memories with a registered
// read, and commands are processed one at a time by a sequencer that reads, modifies
// and writes them back. An accepted command is looked up in S_LOOK; an acknowledge or
// a single value is then registered for transfer from S_ACK or S_VAL, and the next
// command can be taken once it has been handed over. A boundary that is compared with
// the one below passes through S_BCMP; a histogram update scans the boundaries in
// S_SCAN and then writes the bucket counter in S_HITWR; an accepted define clears the
// bucket counters in S_CLR; a histogram read emits one result per cycle while the
// receiver takes them (bucket_total + 3 results).
// Reset. After aresetn is released a clearing pass writes zero to every slot and every
// bucket counter; s_tready stays low during it. Boundary memory is not cleared.
// Stalls. Results sit in an output register; when the receiver holds m_tready low the
// sequencer waits before the next result, and a new command is accepted once the
// previous one has handed over its final result.
module metric_counter_gauge_histogram_table_top #(
    parameter int METRIC_SLOTS = 64,
    parameter int MAX_BUCKETS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // metric_id[5:0], sample[53:6], sample_finite[54], kind[56:55],
    // bucket_index[59:57], bucket_total[63:60]
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // status[1:0], boundary_index[5:2], data[69:6], zero
    output logic [2:0]  m_tuser,    // item_kind[2:0]
    output logic        m_tlast
);
    import mcgh_pkg::*;

    localparam int STRIDE    = MAX_BUCKETS + 1;
    localparam int HIT_DEPTH = METRIC_SLOTS * STRIDE;
    localparam int BND_DEPTH = METRIC_SLOTS * MAX_BUCKETS;
    localparam int ID_W  = (METRIC_SLOTS > 1) ? $clog2(METRIC_SLOTS) : 1;
    localparam int HA_W  = $clog2(HIT_DEPTH);
    localparam int BA_W  = (BND_DEPTH > 1) ? $clog2(BND_DEPTH) : 1;
    localparam int CNT_W = $clog2(STRIDE + 1);
    localparam logic [3:0] BUCKET_CAP = (MAX_BUCKETS < 8) ? 4'(MAX_BUCKETS) : 4'd8;
    localparam logic [CNT_W-1:0] B_CLR_LAST = CNT_W'(STRIDE - 1);

    // Sequencer registers.
    state_t             state_reg, state_next;
    logic [HA_W-1:0]    init_reg, init_next;
    logic [1:0]         cmd_reg;
    logic [5:0]         id_reg;
    logic signed [47:0] sample_reg;
    logic               fin_reg;
    logic [1:0]         kind_reg;
    logic [2:0]         bidx_reg;
    logic [3:0]         btot_reg;
    logic [CNT_W-1:0]   b_reg, b_next;
    logic [47:0]        cum_reg, cum_next;
    logic [1:0]         st_reg, st_next;

    logic    push, out_free;
    result_t push_data;

    // Memories.
    slot_t              slot_mem [METRIC_SLOTS];
    logic signed [47:0] bnd_mem  [BND_DEPTH];
    logic [47:0]        hit_mem  [HIT_DEPTH];

    slot_t              slot_rd_reg;
    logic signed [47:0] bnd_rd_reg;
    logic [47:0]        hit_rd_reg;

    logic              slot_we, slot_re, bnd_we, bnd_re, hit_we, hit_re;
    logic [ID_W-1:0]   slot_wa, slot_ra;
    slot_t             slot_wd;
    logic [BA_W-1:0]   bnd_wa, bnd_ra;
    logic [HA_W-1:0]   hit_wa, hit_ra;
    logic [47:0]       hit_wd;

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re) begin
            slot_rd_reg <= slot_mem[slot_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (bnd_we) begin
            bnd_mem[bnd_wa] <= sample_reg;
        end
        if (bnd_re) begin
            bnd_rd_reg <= bnd_mem[bnd_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (hit_we) begin
            hit_mem[hit_wa] <= hit_wd;
        end
        if (hit_re) begin
            hit_rd_reg <= hit_mem[hit_ra];
        end
    end

    logic s_acc;
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg    <= s_tuser;
            id_reg     <= s_tdata[5:0];
            sample_reg <= s_tdata[53:6];
            fin_reg    <= s_tdata[54];
            kind_reg   <= s_tdata[56:55];
            bidx_reg   <= s_tdata[59:57];
            btot_reg   <= s_tdata[63:60];
        end
        b_reg   <= b_next;
        cum_reg <= cum_next;
        st_reg  <= st_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            init_reg  <= '0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
        end
    end

    // Decoded facts about the current command.
    logic            in_rng;
    logic [ID_W-1:0] slot_idx;
    logic [1:0]      sk;
    logic [3:0]      tot;
    logic            bnd_ge, b_last, init_last, hist_upd;
    logic [1:0]      bst;
    logic [3:0]      tot_eff;
    logic signed [64:0] sum_wide;
    logic signed [63:0] sum_sat;
    logic [47:0]     cnt_inc, hit_inc;
    logic [48:0]     cum_wide;
    logic [47:0]     cum_sat;

    assign in_rng    = 32'(id_reg) < METRIC_SLOTS;
    assign slot_idx  = ID_W'(id_reg);
    assign sk        = in_rng ? slot_rd_reg.kind : KIND_UNUSED;
    assign tot       = in_rng ? slot_rd_reg.total : 4'd0;
    assign bnd_ge    = bnd_rd_reg >= sample_reg;
    assign b_last    = (8'(b_reg) + 8'd1) == 8'(tot);
    assign init_last = 32'(init_reg) == (HIT_DEPTH - 1);
    assign hist_upd  = (sk == KIND_HIST) && fin_reg;

    always_comb begin
        if (sk != KIND_HIST) begin
            bst = ST_UNUSED;
        end else if ({1'b0, bidx_reg} >= tot) begin
            bst = ST_NOBKT;
        end else if (!fin_reg) begin
            bst = ST_REJECT;
        end else begin
            bst = ST_OK;
        end
    end

    assign tot_eff = (kind_reg != KIND_HIST) ? 4'd0 :
                     (btot_reg > BUCKET_CAP) ? BUCKET_CAP : btot_reg;

    // Saturating Q47.16 sum and 48-bit counters.
    assign sum_wide = {slot_rd_reg.value[63], slot_rd_reg.value} + 65'(sample_reg);
    assign sum_sat  = (sum_wide[64] != sum_wide[63]) ?
                      {sum_wide[64], {63{~sum_wide[64]}}} : sum_wide[63:0];
    assign cnt_inc  = (slot_rd_reg.count == CNT_MAX) ? CNT_MAX : slot_rd_reg.count + 48'd1;
    assign hit_inc  = (hit_rd_reg == CNT_MAX) ? CNT_MAX : hit_rd_reg + 48'd1;
    assign cum_wide = {1'b0, cum_reg} + {1'b0, hit_rd_reg};
    assign cum_sat  = cum_wide[48] ? CNT_MAX : cum_wide[47:0];

    function automatic logic [HA_W-1:0] hit_addr(input logic [ID_W-1:0] slot,
                                                 input logic [CNT_W-1:0] b);
        hit_addr = HA_W'(HA_W'(slot) * HA_W'(STRIDE) + HA_W'(b));
    endfunction

    function automatic logic [BA_W-1:0] bnd_addr(input logic [ID_W-1:0] slot,
                                                 input logic [2:0] b);
        bnd_addr = BA_W'(BA_W'(slot) * BA_W'(MAX_BUCKETS) + BA_W'(b));
    endfunction

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: if (init_last) state_next = S_IDLE;
            S_IDLE: if (s_acc) state_next = S_LOOK;
            S_LOOK: begin
                unique case (cmd_reg)
                    CMD_DEFINE: begin
                        if (!in_rng || (kind_reg == KIND_HIST && btot_reg == 4'd0)) begin
                            state_next = S_ACK;
                        end else begin
                            state_next = S_CLR;
                        end
                    end
                    CMD_BOUND: begin
                        state_next = (bst == ST_OK && bidx_reg != 3'd0) ? S_BCMP : S_ACK;
                    end
                    CMD_UPDATE: begin
                        if (!hist_upd) begin
                            state_next = S_ACK;
                        end else if (tot == 4'd0) begin
                            state_next = S_HITWR;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        if (sk == KIND_UNUSED) begin
                            state_next = S_ACK;
                        end else if (sk != KIND_HIST) begin
                            state_next = S_VAL;
                        end else if (tot == 4'd0) begin
                            state_next = S_RINF;
                        end else begin
                            state_next = S_RBKT;
                        end
                    end
                endcase
            end
            S_CLR:   if (b_reg == B_CLR_LAST) state_next = S_ACK;
            S_BCMP:  state_next = S_ACK;
            S_SCAN:  if (bnd_ge || b_last) state_next = S_HITWR;
            S_HITWR: state_next = S_ACK;
            S_RBKT:  if (out_free && b_last) state_next = S_RINF;
            S_RINF:  if (out_free) state_next = S_RSUM;
            S_RSUM:  if (out_free) state_next = S_RCNT;
            S_RCNT:  if (out_free) state_next = S_IDLE;
            S_ACK:   if (out_free) state_next = S_IDLE;
            S_VAL:   if (out_free) state_next = S_IDLE;
            default: state_next = S_INIT;
        endcase
    end

    // Memory controls, datapath and results.
    always_comb begin
        init_next = init_reg;
        b_next    = b_reg;
        cum_next  = cum_reg;
        st_next   = st_reg;
        slot_we = 1'b0; slot_re = 1'b0; bnd_we = 1'b0; bnd_re = 1'b0;
        hit_we  = 1'b0; hit_re  = 1'b0;
        slot_wa = slot_idx;
        slot_ra = ID_W'(s_tdata[5:0]);
        slot_wd = slot_rd_reg;
        bnd_wa  = bnd_addr(slot_idx, bidx_reg);
        bnd_ra  = bnd_addr(slot_idx, bidx_reg - 3'd1);
        hit_wa  = hit_addr(slot_idx, b_reg);
        hit_ra  = hit_addr(slot_idx, b_reg);
        hit_wd  = '0;
        push    = 1'b0;
        push_data = '{status: ST_OK, item_kind: IK_ACK, bidx: 4'd0, data: 64'sd0, last: 1'b1};
        unique case (state_reg)
            S_INIT: begin
                init_next = init_reg + HA_W'(1);
                hit_we    = 1'b1;
                hit_wa    = init_reg;
                slot_we   = 32'(init_reg) < METRIC_SLOTS;
                slot_wa   = ID_W'(init_reg);
                slot_wd   = '0;
            end
            S_IDLE: begin
                slot_re = s_acc;
            end
            S_LOOK: begin
                unique case (cmd_reg)
                    CMD_DEFINE: begin
                        b_next = '0;
                        if (!in_rng) begin
                            st_next = ST_UNUSED;
                        end else if (kind_reg == KIND_HIST && btot_reg == 4'd0) begin
                            st_next = ST_NOBKT;
                        end else begin
                            st_next = ST_OK;
                            slot_we = 1'b1;
                            slot_wd = '{kind: kind_reg, total: tot_eff, value: 64'sd0,
                                        count: 48'd0};
                        end
                    end
                    CMD_BOUND: begin
                        st_next = bst;
                        if (bst == ST_OK) begin
                            bnd_we = (bidx_reg == 3'd0);
                            bnd_re = (bidx_reg != 3'd0);
                        end
                    end
                    CMD_UPDATE: begin
                        st_next = (sk == KIND_UNUSED) ? ST_UNUSED : ST_OK;
                        b_next  = '0;
                        if (fin_reg) begin
                            case (sk)
                                KIND_COUNTER: begin
                                    slot_we = !sample_reg[47];
                                    slot_wd.value = sum_sat;
                                end
                                KIND_GAUGE: begin
                                    slot_we = 1'b1;
                                    slot_wd.value = 64'(sample_reg);
                                end
                                KIND_HIST: begin
                                    slot_we = 1'b1;
                                    slot_wd.value = sum_sat;
                                    slot_wd.count = cnt_inc;
                                end
                                default: ;
                            endcase
                        end
                        if (hist_upd) begin
                            hit_re = (tot == 4'd0);
                            hit_ra = hit_addr(slot_idx, '0);
                            bnd_re = (tot != 4'd0);
                            bnd_ra = bnd_addr(slot_idx, 3'd0);
                        end
                    end
                    default: begin
                        st_next  = (sk == KIND_UNUSED) ? ST_UNUSED : ST_OK;
                        b_next   = '0;
                        cum_next = '0;
                        hit_re   = (sk == KIND_HIST) && (tot != 4'd0);
                        hit_ra   = hit_addr(slot_idx, '0);
                    end
                endcase
            end
            S_CLR: begin
                hit_we = 1'b1;
                b_next = b_reg + CNT_W'(1);
            end
            S_BCMP: begin
                if (bnd_ge) begin
                    st_next = ST_REJECT;
                end else begin
                    bnd_we = 1'b1;
                end
            end
            S_SCAN: begin
                if (bnd_ge) begin
                    hit_re = 1'b1;
                end else begin
                    b_next = b_reg + CNT_W'(1);
                    hit_ra = hit_addr(slot_idx, b_reg + CNT_W'(1));
                    bnd_ra = bnd_addr(slot_idx, 3'(b_reg + CNT_W'(1)));
                    hit_re = b_last;
                    bnd_re = !b_last;
                end
            end
            S_HITWR: begin
                hit_we = 1'b1;
                hit_wd = hit_inc;
            end
            S_RBKT: begin
                push = 1'b1;
                push_data = '{status: ST_OK, item_kind: IK_BKT, bidx: 4'(b_reg),
                              data: 64'(cum_sat), last: 1'b0};
                if (out_free) begin
                    cum_next = cum_sat;
                    b_next   = b_reg + CNT_W'(1);
                    hit_re   = !b_last;
                    hit_ra   = hit_addr(slot_idx, b_reg + CNT_W'(1));
                end
            end
            S_RINF: begin
                push = 1'b1;
                push_data = '{status: ST_OK, item_kind: IK_BKT, bidx: INF_INDEX,
                              data: 64'(slot_rd_reg.count), last: 1'b0};
            end
            S_RSUM: begin
                push = 1'b1;
                push_data = '{status: ST_OK, item_kind: IK_SUM, bidx: 4'd0,
                              data: slot_rd_reg.value, last: 1'b0};
            end
            S_RCNT: begin
                push = 1'b1;
                push_data = '{status: ST_OK, item_kind: IK_COUNT, bidx: 4'd0,
                              data: 64'(slot_rd_reg.count), last: 1'b1};
            end
            S_ACK: begin
                push = 1'b1;
                push_data = '{status: st_reg, item_kind: IK_ACK, bidx: 4'd0,
                              data: 64'sd0, last: 1'b1};
            end
            S_VAL: begin
                push = 1'b1;
                push_data = '{status: ST_OK, item_kind: IK_VALUE, bidx: 4'd0,
                              data: slot_rd_reg.value, last: 1'b1};
            end
            default: ;
        endcase
    end

    mcgh_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push && out_free),
        .push_data (push_data),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // No command may be taken while the clearing pass runs.
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT) |-> !s_tready)
        else $error("command accepted during clearing pass");

    // The boundary scan never runs past the slot's bucket total.
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (8'(b_reg) < 8'(tot)))
        else $error("boundary scan index out of range");

    // A final result leaves the sequencer only when it returns to idle.
    a_last_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && out_free && push_data.last) |=> (state_reg == S_IDLE))
        else $error("final result without return to idle");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for metric_counter_gauge_histogram_table_top.
// Depends on mcgh_pkg and the table RTL; drives commands and checks every result transfer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcgh_pkg::*;

    localparam int SLOTS   = 64;
    localparam int BUCKETS = 8;
    localparam int LIMIT   = 400000;

    // One command as queued for the driver.
    typedef struct packed {
        cmd_t         cmd;
        logic [5:0]   id;
        logic [47:0]  smp;
        logic         fin;
        slot_kind_t   kind;
        logic [2:0]   bidx;
        logic [3:0]   btot;
    } command_t;

    // One expected result transfer.
    typedef struct packed {
        status_t            status;
        item_kind_t         ikind;
        logic [3:0]         bidx;
        logic signed [63:0] data;
        logic               last;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    metric_counter_gauge_histogram_table_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // The table as the testbench believes it to be.
    slot_kind_t         tbl_kind   [SLOTS];
    logic [3:0]         tbl_total  [SLOTS];
    logic signed [47:0] tbl_bound  [SLOTS][BUCKETS];
    logic signed [63:0] tbl_value  [SLOTS];
    logic [47:0]        tbl_count  [SLOTS];
    logic [47:0]        tbl_hits   [SLOTS][BUCKETS+1];

    command_t pending_cmds[$];
    answer_t  expected_results[$];
    int       failures = 0;
    int       cycles = 0;
    bit       stim_done;
    bit       hold_sender;
    bit       calm;
    int       s_gap;
    int       m_gap;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sd9223372036854775807) return {1'b0, {63{1'b1}}};
        if (s < -65'sd9223372036854775808) return {1'b1, 63'd0};
        return s[63:0];
    endfunction

    function automatic logic [47:0] bump(logic [47:0] c);
        return (c == CNT_MAX) ? c : c + 48'd1;
    endfunction

    function automatic void push_result(status_t st, item_kind_t ik, logic [3:0] bi,
                                        logic signed [63:0] d, logic l);
        answer_t a;
        a.status = st; a.ikind = ik; a.bidx = bi; a.data = d; a.last = l;
        expected_results.insert(expected_results.size(), a);
    endfunction

    function automatic void clear_values(int id);
        tbl_value[id] = '0;
        tbl_count[id] = '0;
        for (int b = 0; b <= BUCKETS; b++) tbl_hits[id][b] = '0;
    endfunction

    // Applies one accepted command to the table model and queues its results.
    function automatic void apply_command(command_t c);
        int                 id;
        slot_kind_t         sk;
        int                 tot;
        logic signed [47:0] s;
        int                 b;
        logic [47:0]        cum;
        status_t            st;
        id  = c.id;
        sk  = tbl_kind[id];
        tot = tbl_total[id];
        s   = c.smp;
        case (c.cmd)
            CMD_DEFINE: begin
                if (c.kind == KIND_HIST && c.btot == 0) begin
                    push_result(ST_NOBKT, IK_ACK, 4'd0, '0, 1'b1);
                end else begin
                    tbl_kind[id]  = c.kind;
                    tbl_total[id] = (c.kind != KIND_HIST) ? 4'd0 :
                                    (c.btot > BUCKETS) ? 4'(BUCKETS) : c.btot;
                    clear_values(id);
                    push_result(ST_OK, IK_ACK, 4'd0, '0, 1'b1);
                end
            end
            CMD_BOUND: begin
                st = ST_OK;
                if (sk != KIND_HIST) st = ST_UNUSED;
                else if (c.bidx >= tot) st = ST_NOBKT;
                else if (!c.fin) st = ST_REJECT;
                else if (c.bidx > 0 && s <= tbl_bound[id][c.bidx-1]) st = ST_REJECT;
                if (st == ST_OK) begin
                    tbl_bound[id][c.bidx] = s;
                end
                push_result(st, IK_ACK, 4'd0, '0, 1'b1);
            end
            CMD_UPDATE: begin
                if (sk == KIND_UNUSED) begin
                    push_result(ST_UNUSED, IK_ACK, 4'd0, '0, 1'b1);
                end else begin
                    if (c.fin) begin
                        if (sk == KIND_COUNTER) begin
                            if (s >= 0) tbl_value[id] = sat_sum(tbl_value[id], 64'(s));
                        end else if (sk == KIND_GAUGE) begin
                            tbl_value[id] = 64'(s);
                        end else begin
                            tbl_value[id] = sat_sum(tbl_value[id], 64'(s));
                            tbl_count[id] = bump(tbl_count[id]);
                            for (b = 0; b < tot; b++)
                                if (tbl_bound[id][b] >= s) break;
                            tbl_hits[id][b] = bump(tbl_hits[id][b]);
                        end
                    end
                    push_result(ST_OK, IK_ACK, 4'd0, '0, 1'b1);
                end
            end
            default: begin
                if (sk == KIND_UNUSED) begin
                    push_result(ST_UNUSED, IK_ACK, 4'd0, '0, 1'b1);
                end else if (sk != KIND_HIST) begin
                    push_result(ST_OK, IK_VALUE, 4'd0, tbl_value[id], 1'b1);
                end else begin
                    cum = '0;
                    for (b = 0; b < tot; b++) begin
                        cum = (49'(cum) + 49'(tbl_hits[id][b]) > 49'(CNT_MAX)) ? CNT_MAX :
                              cum + tbl_hits[id][b];
                        push_result(ST_OK, IK_BKT, 4'(b), 64'(cum), 1'b0);
                    end
                    push_result(ST_OK, IK_BKT, INF_INDEX, 64'(tbl_count[id]), 1'b0);
                    push_result(ST_OK, IK_SUM, 4'd0, tbl_value[id], 1'b0);
                    push_result(ST_OK, IK_COUNT, 4'd0, 64'(tbl_count[id]), 1'b1);
                end
            end
        endcase
    endfunction

    function automatic command_t make_cmd(cmd_t op, int id, logic [47:0] smp, logic fin,
                                          slot_kind_t k, int bi, int bt);
        command_t c;
        c.cmd = op; c.id = 6'(id); c.smp = smp; c.fin = fin;
        c.kind = k; c.bidx = 3'(bi); c.btot = 4'(bt);
        return c;
    endfunction

    // Random bits everywhere, including fields the command does not use.
    function automatic command_t noise_cmd();
        command_t c;
        c = $bits(command_t)'({$urandom, $urandom, $urandom});
        return c;
    endfunction

    // Tracks which boundaries are written in the stimulus order, so that no update or
    // read ever meets a boundary that was never written.
    logic gen_bset [SLOTS][BUCKETS];
    int   gen_total[SLOTS];
    slot_kind_t gen_kind[SLOTS];

    function automatic bit hist_ready(int id);
        for (int b = 0; b < gen_total[id]; b++) if (!gen_bset[id][b]) return 1'b0;
        return 1'b1;
    endfunction

    // Queues a command, rewriting updates and reads that would touch unwritten bounds.
    function automatic void queue_cmd(command_t c);
        int id;
        id = c.id;
        if ((c.cmd == CMD_UPDATE || c.cmd == CMD_READ) && gen_kind[id] == KIND_HIST &&
            !hist_ready(id))
            c.cmd = CMD_BOUND;
        if (c.cmd == CMD_DEFINE && !(c.kind == KIND_HIST && c.btot == 0)) begin
            gen_kind[id]  = c.kind;
            gen_total[id] = (c.kind != KIND_HIST) ? 0 : (c.btot > BUCKETS) ? BUCKETS : c.btot;
        end
        // A boundary above the first is compared with the one below, so that one must
        // already hold a value; otherwise the write goes to the first boundary.
        if (c.cmd == CMD_BOUND && gen_kind[id] == KIND_HIST && c.fin && c.bidx != 3'd0 &&
            int'(c.bidx) < gen_total[id] && !gen_bset[id][c.bidx-1])
            c.bidx = 3'd0;
        // A boundary write is tracked only when it is surely accepted: a finite first
        // boundary of a histogram, or the rising sequences that fill_hist issues.
        if (c.cmd == CMD_BOUND && gen_kind[id] == KIND_HIST && c.fin && c.bidx == 3'd0 &&
            gen_total[id] > 0)
            gen_bset[id][0] = 1'b1;
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Defines a histogram and writes all its boundaries in rising order.
    function automatic void fill_hist(int id, int bt, logic signed [47:0] lo, int step);
        logic signed [47:0] v;
        int tot;
        queue_cmd(make_cmd(CMD_DEFINE, id, 48'($urandom), 1'($urandom), KIND_HIST,
                           $urandom, bt));
        tot = gen_total[id];
        v = lo;
        for (int b = 0; b < tot; b++) begin
            queue_cmd(make_cmd(CMD_BOUND, id, v, 1'b1, KIND_HIST, b, $urandom));
            gen_bset[id][b] = 1'b1;
            v = v + 48'(step) + 48'($urandom_range(0, step));
        end
    endfunction

    function automatic logic [47:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return 48'({$urandom, $urandom});
            1:       return 48'($signed($urandom_range(0, 600000)) - 300000);
            2:       return $urandom_range(0, 1) ? {1'b0, {47{1'b1}}} : {1'b1, 47'd0};
            default: return 48'($urandom_range(0, 40)) <<< 16;
        endcase
    endfunction

    initial begin
        int id;
        int n;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_kind[i] = KIND_UNUSED; tbl_total[i] = '0; gen_kind[i] = KIND_UNUSED;
            gen_total[i] = 0; clear_values(i);
            for (int b = 0; b < BUCKETS; b++) begin
                tbl_bound[i][b] = '0; gen_bset[i][b] = 1'b0;
            end
        end

        // Directed part: every command and each corner named for the table.
        queue_cmd(make_cmd(CMD_READ, 63, '0, 1'b1, KIND_UNUSED, 0, 0));     // unused read
        queue_cmd(make_cmd(CMD_UPDATE, 0, 48'd5, 1'b1, KIND_UNUSED, 0, 0)); // unused update
        queue_cmd(make_cmd(CMD_BOUND, 1, 48'd5, 1'b1, KIND_UNUSED, 0, 0));  // not a histogram
        queue_cmd(make_cmd(CMD_DEFINE, 2, '0, 1'b1, KIND_HIST, 0, 0));      // no buckets
        queue_cmd(make_cmd(CMD_DEFINE, 3, '0, 1'b1, KIND_COUNTER, 0, 15));
        queue_cmd(make_cmd(CMD_UPDATE, 3, {1'b0, {47{1'b1}}}, 1'b1, KIND_UNUSED, 0, 0));
        queue_cmd(make_cmd(CMD_UPDATE, 3, {1'b1, 47'd0}, 1'b1, KIND_UNUSED, 0, 0)); // negative
        queue_cmd(make_cmd(CMD_UPDATE, 3, 48'd7, 1'b0, KIND_UNUSED, 0, 0));   // non-finite
        queue_cmd(make_cmd(CMD_READ, 3, '0, 1'b1, KIND_UNUSED, 0, 0));
        queue_cmd(make_cmd(CMD_DEFINE, 4, '0, 1'b1, KIND_GAUGE, 0, 0));
        queue_cmd(make_cmd(CMD_UPDATE, 4, {1'b1, 47'd0}, 1'b1, KIND_UNUSED, 0, 0));
        queue_cmd(make_cmd(CMD_READ, 4, '0, 1'b1, KIND_UNUSED, 0, 0));
        fill_hist(5, 15, {1'b1, 47'd1}, 70000);                             // total saturates
        queue_cmd(make_cmd(CMD_BOUND, 5, 48'd0, 1'b0, KIND_UNUSED, 2, 0));  // non-finite bound
        queue_cmd(make_cmd(CMD_BOUND, 5, {1'b1, 47'd0}, 1'b1, KIND_UNUSED, 3, 0)); // not rising
        queue_cmd(make_cmd(CMD_UPDATE, 5, {1'b0, {47{1'b1}}}, 1'b1, KIND_UNUSED, 0, 0)); // +Inf
        queue_cmd(make_cmd(CMD_UPDATE, 5, {1'b1, 47'd0}, 1'b1, KIND_UNUSED, 0, 0));
        queue_cmd(make_cmd(CMD_READ, 5, '0, 1'b1, KIND_UNUSED, 0, 0));
        fill_hist(6, 1, 48'sd0, 10);
        queue_cmd(make_cmd(CMD_BOUND, 6, 48'd9, 1'b1, KIND_UNUSED, 1, 0));  // index too high
        queue_cmd(make_cmd(CMD_DEFINE, 6, '0, 1'b1, KIND_UNUSED, 0, 0));    // kind 0 define
        queue_cmd(make_cmd(CMD_READ, 6, '0, 1'b1, KIND_UNUSED, 0, 0));

        // Random part: mostly defined slots with well-formed histograms, some noise.
        n = 0;
        while (n < 300) begin
            id = $urandom_range(0, 15);
            case ($urandom_range(0, 19))
                0: begin
                    fill_hist(id, $urandom_range(1, 9),
                              48'($signed($urandom_range(0, 400000)) - 200000),
                              $urandom_range(1, 3) << 16);
                    n += 1 + gen_total[id];
                end
                1, 2: begin
                    queue_cmd(make_cmd(CMD_DEFINE, id, 48'($urandom), 1'($urandom),
                                       slot_kind_t'($urandom_range(1, 2)), $urandom, $urandom));
                    n++;
                end
                3: begin
                    queue_cmd(noise_cmd());
                    n++;
                end
                4, 5, 6, 7, 8: begin
                    queue_cmd(make_cmd(CMD_READ, id, 48'($urandom), 1'($urandom),
                                       slot_kind_t'($urandom_range(0, 3)),
                                       $urandom, $urandom));
                    n++;
                end
                default: begin
                    queue_cmd(make_cmd(CMD_UPDATE, id, rand_sample(), $urandom_range(0, 9) != 0,
                                       slot_kind_t'($urandom_range(0, 3)), $urandom, $urandom));
                    n++;
                end
            endcase
        end
    end

    // Driver: present queued commands, idling in random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_gap    <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) apply_command({cmd_t'(s_tuser), s_tdata[5:0], s_tdata[53:6],
                                         s_tdata[54], slot_kind_t'(s_tdata[56:55]),
                                         s_tdata[59:57], s_tdata[63:60]});
            if (s_gap > 0) begin
                s_gap    <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                s_gap    <= $urandom_range(0, 10);
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0 && !hold_sender) begin
                command_t c;
                c = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= c.cmd;
                s_tdata  <= {c.btot, c.bidx, c.kind, c.fin, c.smp, c.id};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap    <= 0;
        end else if (m_gap > 0) begin
            m_gap    <= m_gap - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_gap    <= $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: compare every result transfer with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            answer_t exp_r;
            answer_t got;
            got.status = status_t'(m_tdata[1:0]);
            got.bidx   = m_tdata[5:2];
            got.data   = m_tdata[69:6];
            got.ikind  = item_kind_t'(m_tuser);
            got.last   = m_tlast;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $realtime, got);
                failures++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status || got.ikind !== exp_r.ikind ||
                    got.bidx !== exp_r.bidx || got.data !== exp_r.data ||
                    got.last !== exp_r.last) begin
                    $display("%0t: mismatch, expected st=%0d ik=%0d bi=%0d d=%0d l=%0d",
                             $realtime, exp_r.status, exp_r.ikind, exp_r.bidx, exp_r.data,
                             exp_r.last);
                    $display("%0t:           actual st=%0d ik=%0d bi=%0d d=%0d l=%0d",
                             $realtime, got.status, got.ikind, got.bidx, got.data, got.last);
                    failures++;
                end
            end
        end
    end

    // Cycle limit: sized for the reset clearing pass plus 300-odd commands of up to
    // eleven results each, every one waiting out the longest stalls on both sides.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[metric_counter_gauge_histogram_table_top] ERROR");
            $finish;
        end
    end

    initial begin
        int total;
        hold_sender = 1'b0;
        calm        = 1'b0;
        aresetn     = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Once, midway, the sender waits until the table has answered everything.
        total = pending_cmds.size();
        wait (pending_cmds.size() <= total / 2);
        hold_sender = 1'b1;
        wait (expected_results.size() == 0 && !s_tvalid);
        repeat (20) @(posedge aclk);
        hold_sender = 1'b0;

        // The final stretch runs with no idling at all.
        wait (pending_cmds.size() <= 40);
        calm = 1'b1;
        wait (pending_cmds.size() == 0);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (failures == 0) begin
            $display("[metric_counter_gauge_histogram_table_top] OK");
        end else begin
            $display("[metric_counter_gauge_histogram_table_top] ERROR");
        end
        $finish;
    end
endmodule
